// ===== rtl/pfde_pkg.sv =====
// package for the page framebuffer draw engine
// holds screen constants, command, color and clip register codes and the sequencer state type
// no dependencies
`default_nettype none
package pfde_pkg;
	localparam int SCREEN_COLS = 128;
	localparam int SCREEN_ROWS = 64;

	typedef enum logic [2:0] {
		CMD_PIXEL  = 3'd0,
		CMD_HLINE  = 3'd1,
		CMD_VLINE  = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_BEGIN  = 3'd4,
		CMD_FULL   = 3'd5,
		CMD_READ   = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	localparam logic [1:0] COLOR_CLEAR  = 2'd0;
	localparam logic [1:0] COLOR_SET    = 2'd1;
	localparam logic [1:0] COLOR_INVERT = 2'd2;

	localparam logic [1:0] REG_CLIP_SX = 2'd0;
	localparam logic [1:0] REG_CLIP_SY = 2'd1;
	localparam logic [1:0] REG_CLIP_EX = 2'd2;
	localparam logic [1:0] REG_CLIP_EY = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLIP,
		ST_RD,
		ST_WAIT,
		ST_WR,
		ST_CLEAR,
		ST_RREAD,
		ST_RWAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/pfde_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/page_framebuffer_draw_engine_top.sv =====
// page framebuffer draw engine: one command per input beat, one result beat per command
// a pixel or run is clipped, then walks its bytes one at a time (read, wait, write),
// a horizontal run up to SCREEN_COLS bytes, a vertical run one per page touched
// clear screen sweeps the whole store one byte a cycle through the ram write port
// after reset a clearing pass over the whole store runs before the first beat is taken
// depends on pfde_pkg and pfde_ram
`default_nettype none
module page_framebuffer_draw_engine_top #(
	parameter int SCREEN_COLS = pfde_pkg::SCREEN_COLS,
	parameter int SCREEN_ROWS = pfde_pkg::SCREEN_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// command[2:0], pos_x[11:3], pos_y[20:12], run_length[28:21], color[30:29]
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0], dirty_x_start[15:8], dirty_y_start[22:16], dirty_x_end[30:23],
	// dirty_y_end[37:31]
	output logic [39:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam int PAGES = (SCREEN_ROWS + 7) / 8;
	localparam int DEPTH = SCREEN_COLS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(SCREEN_COLS);

	// input fields
	logic [2:0]        command;
	logic signed [8:0] pos_x, pos_y;
	logic [7:0]        run_length;
	logic [1:0]        color;
	assign command    = s_tdata[2:0];
	assign pos_x      = s_tdata[11:3];
	assign pos_y      = s_tdata[20:12];
	assign run_length = s_tdata[28:21];
	assign color      = s_tdata[30:29];

	// configuration registers
	logic [7:0] clip_sx_q, clip_ex_q;
	logic [6:0] clip_sy_q, clip_ey_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_sx_q <= 8'd0;
			clip_sy_q <= 7'd0;
			clip_ex_q <= 8'd127;
			clip_ey_q <= 7'd63;
		end else if (cfg_we) begin
			case (cfg_index)
				pfde_pkg::REG_CLIP_SX: clip_sx_q <= cfg_data;
				pfde_pkg::REG_CLIP_SY: clip_sy_q <= cfg_data[6:0];
				pfde_pkg::REG_CLIP_EX: clip_ex_q <= cfg_data;
				pfde_pkg::REG_CLIP_EY: clip_ey_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// latched command
	pfde_pkg::state_t state_q, state_d;
	logic [2:0]        cmd_q;
	logic [1:0]        color_q;
	logic signed [10:0] x0_q, y0_q, x1_q, y1_q;   // requested box, half-open
	logic [9:0]        lx_q, hx_q, ly_q, hy_q;    // clipped box
	logic [9:0]        cx_q;                     // current column
	logic [9:0]        cy_q;                     // current row; bits 9:3 give the page
	logic [AW:0]       sweep_q;
	logic [7:0]        rd_q;
	logic [7:0]        rsx_q, rex_q;
	logic [6:0]        rsy_q, rey_q;
	logic              outv_q;

	// clipping: max/min of request, clip window and screen
	logic signed [10:0] lx_c, hx_c, ly_c, hy_c;
	always_comb begin
		lx_c = x0_q;
		if ($signed({3'b0, clip_sx_q}) > lx_c) lx_c = $signed({3'b0, clip_sx_q});
		if (lx_c < 0) lx_c = '0;
		hx_c = x1_q;
		if ($signed({3'b0, clip_ex_q}) < hx_c) hx_c = $signed({3'b0, clip_ex_q});
		if (hx_c > SCREEN_COLS) hx_c = 11'(SCREEN_COLS);
		ly_c = y0_q;
		if ($signed({4'b0, clip_sy_q}) > ly_c) ly_c = $signed({4'b0, clip_sy_q});
		if (ly_c < 0) ly_c = '0;
		hy_c = y1_q;
		if ($signed({4'b0, clip_ey_q}) < hy_c) hy_c = $signed({4'b0, clip_ey_q});
		if (hy_c > SCREEN_ROWS) hy_c = 11'(SCREEN_ROWS);
	end

	// bit mask of current page: rows ly..hy-1 within page cy
	logic [7:0] mask_c;
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mask_c[b] = ({cy_q[9:3], 3'(b)} >= ly_q) && ({cy_q[9:3], 3'(b)} < hy_q);
		end
	end

	// ram port
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [AW-1:0] addr_c;
	assign addr_c = AW'(cx_q[CW-1:0]) + AW'(cy_q[9:3]) * AW'(SCREEN_COLS);

	pfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		raddr = addr_c;
		waddr = (state_q == pfde_pkg::ST_CLEAR) ? sweep_q[AW-1:0] : addr_c;
		we    = (state_q == pfde_pkg::ST_CLEAR) || (state_q == pfde_pkg::ST_WR);
		case (color_q)
			pfde_pkg::COLOR_SET:    wdata = rdata | mask_c;
			pfde_pkg::COLOR_INVERT: wdata = rdata ^ mask_c;
			default:                wdata = rdata & ~mask_c;
		endcase
		if (state_q == pfde_pkg::ST_CLEAR) wdata = 8'd0;
	end

	logic last_col, last_page;
	assign last_col  = (cx_q + 10'd1) >= hx_q;
	assign last_page = ({cy_q[9:3], 3'b0} + 10'd8) >= hy_q;

	// read command address check
	logic rd_ok;
	assign rd_ok = !x0_q[10] && !y0_q[10] && (x0_q < SCREEN_COLS) && ((y0_q >>> 3) < PAGES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfde_pkg::ST_IDLE:  if (s_tvalid) begin
				case (pfde_pkg::cmd_t'(command))
					pfde_pkg::CMD_PIXEL, pfde_pkg::CMD_HLINE,
					pfde_pkg::CMD_VLINE: state_d = pfde_pkg::ST_CLIP;
					pfde_pkg::CMD_CLEAR: state_d = pfde_pkg::ST_CLEAR;
					pfde_pkg::CMD_READ:  state_d = pfde_pkg::ST_RREAD;
					default:             state_d = pfde_pkg::ST_OUT;
				endcase
			end
			pfde_pkg::ST_CLIP:  state_d = (lx_c >= hx_c || ly_c >= hy_c) ?
				pfde_pkg::ST_OUT : pfde_pkg::ST_RD;
			pfde_pkg::ST_RD:    state_d = pfde_pkg::ST_WAIT;
			pfde_pkg::ST_WAIT:  state_d = pfde_pkg::ST_WR;
			pfde_pkg::ST_WR:    state_d = (last_col && last_page) ?
				pfde_pkg::ST_OUT : pfde_pkg::ST_RD;
			pfde_pkg::ST_CLEAR: state_d = (sweep_q == (AW+1)'(DEPTH - 1)) ?
				(cmd_q == pfde_pkg::CMD_CLEAR ? pfde_pkg::ST_OUT : pfde_pkg::ST_IDLE)
				: pfde_pkg::ST_CLEAR;
			pfde_pkg::ST_RREAD: state_d = rd_ok ? pfde_pkg::ST_RWAIT : pfde_pkg::ST_OUT;
			pfde_pkg::ST_RWAIT: state_d = pfde_pkg::ST_OUT;
			pfde_pkg::ST_OUT:   state_d = (!outv_q || m_tready) ? pfde_pkg::ST_IDLE :
				pfde_pkg::ST_OUT;
			default:            state_d = pfde_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == pfde_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pfde_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// datapath and region registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= pfde_pkg::CMD_NONE;
			sweep_q <= '0;
			rsx_q <= '0; rsy_q <= '0; rex_q <= '0; rey_q <= '0;
			outv_q  <= 1'b0;
		end else begin
			if (outv_q && m_tready) outv_q <= 1'b0;
			case (state_q)
				pfde_pkg::ST_IDLE: if (s_tvalid) begin
					cmd_q   <= command;
					color_q <= color;
					rd_q    <= 8'd0;
					sweep_q <= '0;
					x0_q <= 11'(pos_x);
					y0_q <= 11'(pos_y);
					// read address ready for the ram on the next cycle
					cx_q <= 10'(pos_x);
					cy_q <= 10'(pos_y);
					x1_q <= 11'(pos_x) + ((command == pfde_pkg::CMD_HLINE) ?
						$signed({3'b0, run_length}) : 11'sd1);
					y1_q <= 11'(pos_y) + ((command == pfde_pkg::CMD_VLINE) ?
						$signed({3'b0, run_length}) : 11'sd1);
					if (command == pfde_pkg::CMD_BEGIN) begin
						rsx_q <= 8'(SCREEN_COLS); rsy_q <= 7'(SCREEN_ROWS);
						rex_q <= '0; rey_q <= '0;
					end
					if (command == pfde_pkg::CMD_FULL || command == pfde_pkg::CMD_CLEAR) begin
						rsx_q <= '0; rsy_q <= '0;
						rex_q <= 8'(SCREEN_COLS); rey_q <= 7'(SCREEN_ROWS);
					end
				end
				pfde_pkg::ST_CLIP: begin
					lx_q <= 10'(lx_c); hx_q <= 10'(hx_c);
					ly_q <= 10'(ly_c); hy_q <= 10'(hy_c);
					cx_q <= 10'(lx_c); cy_q <= 10'(ly_c);
					if (!(lx_c >= hx_c || ly_c >= hy_c)) begin
						if (10'(lx_c) < 10'(rsx_q)) rsx_q <= 8'(lx_c);
						if (10'(ly_c) < 10'(rsy_q)) rsy_q <= 7'(ly_c);
						if (10'(hx_c) > 10'(rex_q)) rex_q <= 8'(hx_c);
						if (10'(hy_c) > 10'(rey_q)) rey_q <= 7'(hy_c);
					end
				end
				pfde_pkg::ST_WR: begin
					if (last_col) begin
						cx_q <= lx_q;
						cy_q <= {cy_q[9:3], 3'b0} + 10'd8;
					end else begin
						cx_q <= cx_q + 10'd1;
					end
				end
				pfde_pkg::ST_CLEAR: sweep_q <= sweep_q + 1'b1;
				pfde_pkg::ST_RWAIT: rd_q <= rdata;
				default: ;
			endcase
			if (state_q != pfde_pkg::ST_OUT && state_d == pfde_pkg::ST_OUT) outv_q <= 1'b1;
		end
	end

	// result fields come from the region registers and the read byte, stable in the output state
	assign m_tvalid = outv_q;
	assign m_tdata  = {2'b0, rey_q, rex_q, rsy_q, rsx_q, rd_q};

	// a write to the ram happens only while drawing or clearing
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == pfde_pkg::ST_WR || state_q == pfde_pkg::ST_CLEAR))
		else $error("ram write outside draw or clear");
	// no new beat accepted while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken with result pending");
	// a result beat is raised only in the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (state_q == pfde_pkg::ST_OUT))
		else $error("result without command");
endmodule
`default_nettype wire

// ===== sim/page_framebuffer_draw_engine_top_test.sv =====
// testbench for the page framebuffer draw engine: drawing, clipping, dirty rectangle, read back
// keeps its own frame store and clip window and checks every result beat in order
// depends on pfde_pkg and page_framebuffer_draw_engine_top
`default_nettype none
module page_framebuffer_draw_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS  = pfde_pkg::SCREEN_COLS;
	localparam int ROWS  = pfde_pkg::SCREEN_ROWS;
	localparam int PAGES = (ROWS + 7) / 8;

	typedef struct packed {
		logic [6:0] dirty_y_end;
		logic [7:0] dirty_x_end;
		logic [6:0] dirty_y_start;
		logic [7:0] dirty_x_start;
		logic [7:0] read_data;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	// model state
	logic [7:0] pixel_bytes [COLS*PAGES];
	int         rect_x0, rect_y0, rect_x1, rect_y1;
	int         win_x0, win_y0, win_x1, win_y1;
	result_t    expected_results [$];
	int         error_count = 0;
	int         beats_checked = 0;
	int         draw_count;
	int         read_count;

	page_framebuffer_draw_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic int imax(input int a, input int b);
		return a > b ? a : b;
	endfunction

	function automatic int imin(input int a, input int b);
		return a < b ? a : b;
	endfunction

	// clip a box, grow the rectangle and paint every pixel in it
	function automatic void paint_box(input int x0, input int y0, input int x1, input int y1,
			input logic [1:0] color);
		int lx, hx, ly, hy, idx;
		logic [7:0] bitmask;
		lx = imax(imax(x0, win_x0), 0);
		hx = imin(imin(x1, win_x1), COLS);
		ly = imax(imax(y0, win_y0), 0);
		hy = imin(imin(y1, win_y1), ROWS);
		if (lx >= hx || ly >= hy)
			return;
		draw_count++;
		rect_x0 = imin(rect_x0, lx);
		rect_y0 = imin(rect_y0, ly);
		rect_x1 = imax(rect_x1, hx);
		rect_y1 = imax(rect_y1, hy);
		for (int y = ly; y < hy; y++) begin
			for (int x = lx; x < hx; x++) begin
				idx = x + (y / 8) * COLS;
				bitmask = 8'd1 << (y % 8);
				if (color == pfde_pkg::COLOR_SET)
					pixel_bytes[idx] |= bitmask;
				else if (color == pfde_pkg::COLOR_INVERT)
					pixel_bytes[idx] ^= bitmask;
				else
					pixel_bytes[idx] &= ~bitmask;
			end
		end
	endfunction

	// apply one command and return the result beat it should produce
	function automatic result_t predict_command(input logic [31:0] item);
		pfde_pkg::cmd_t cmd;
		int x, y, len;
		logic [1:0] color;
		result_t r;
		cmd = pfde_pkg::cmd_t'(item[2:0]);
		x = $signed(item[11:3]);
		y = $signed(item[20:12]);
		len = item[28:21];
		color = item[30:29];
		r.read_data = 8'd0;
		case (cmd)
			pfde_pkg::CMD_PIXEL: paint_box(x, y, x + 1, y + 1, color);
			pfde_pkg::CMD_HLINE: paint_box(x, y, x + len, y + 1, color);
			pfde_pkg::CMD_VLINE: paint_box(x, y, x + 1, y + len, color);
			pfde_pkg::CMD_CLEAR: begin
				foreach (pixel_bytes[i])
					pixel_bytes[i] = 8'd0;
				rect_x0 = 0; rect_y0 = 0; rect_x1 = COLS; rect_y1 = ROWS;
			end
			pfde_pkg::CMD_BEGIN: begin
				rect_x0 = COLS; rect_y0 = ROWS; rect_x1 = 0; rect_y1 = 0;
			end
			pfde_pkg::CMD_FULL: begin
				rect_x0 = 0; rect_y0 = 0; rect_x1 = COLS; rect_y1 = ROWS;
			end
			pfde_pkg::CMD_READ: begin
				read_count++;
				if (x >= 0 && y >= 0 && x < COLS && y / 8 < PAGES)
					r.read_data = pixel_bytes[x + (y / 8) * COLS];
			end
			default: ;
		endcase
		r.dirty_x_start = rect_x0[7:0];
		r.dirty_y_start = rect_y0[6:0];
		r.dirty_x_end   = rect_x1[7:0];
		r.dirty_y_end   = rect_y1[6:0];
		return r;
	endfunction

	function automatic logic [31:0] pack_command(input pfde_pkg::cmd_t cmd, input int x,
			input int y, input int len, input logic [1:0] color);
		logic [8:0] px, py;
		px = x[8:0];
		py = y[8:0];
		return {1'b0, color, len[7:0], py, px, cmd};
	endfunction

	// send one command beat with burst gaps; valid stays up into the next beat of a burst
	task automatic send_command(input logic [31:0] item);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		expected_results.push_back(predict_command(item));
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write one clip register, block idle; enable is dropped by the caller
	task automatic write_clip(input logic [1:0] index, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value[7:0];
		@(posedge clk);
		case (index)
			pfde_pkg::REG_CLIP_SX: win_x0 = value & 8'hFF;
			pfde_pkg::REG_CLIP_SY: win_y0 = value & 7'h7F;
			pfde_pkg::REG_CLIP_EX: win_x1 = value & 8'hFF;
			default:               win_y1 = value & 7'h7F;
		endcase
	endtask

	task automatic set_window(input int x0, input int y0, input int x1, input int y1);
		wait_drained();
		write_clip(pfde_pkg::REG_CLIP_SX, x0);
		write_clip(pfde_pkg::REG_CLIP_SY, y0);
		write_clip(pfde_pkg::REG_CLIP_EX, x1);
		write_clip(pfde_pkg::REG_CLIP_EY, y1);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [1:0] any_color();
		return 2'($urandom_range(0, 3));
	endfunction

	// receiver stall pattern and result check
	always @(posedge clk) begin
		result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[37:0];
				if (expected_results.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = expected_results.pop_front();
					beats_checked++;
					if (got.read_data !== want.read_data)
						report($sformatf("read_data %h want %h", got.read_data, want.read_data));
					if (got.dirty_x_start !== want.dirty_x_start)
						report($sformatf("dirty_x_start %0d want %0d",
							got.dirty_x_start, want.dirty_x_start));
					if (got.dirty_y_start !== want.dirty_y_start)
						report($sformatf("dirty_y_start %0d want %0d",
							got.dirty_y_start, want.dirty_y_start));
					if (got.dirty_x_end !== want.dirty_x_end)
						report($sformatf("dirty_x_end %0d want %0d",
							got.dirty_x_end, want.dirty_x_end));
					if (got.dirty_y_end !== want.dirty_y_end)
						report($sformatf("dirty_y_end %0d want %0d",
							got.dirty_y_end, want.dirty_y_end));
				end
			end
			m_tready <= (($time / 2000) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// directed corners: extremes of fields, every command, clipping and colors
	task automatic test_directed();
		send_command(pack_command(pfde_pkg::CMD_READ, 0, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_BEGIN, 0, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_PIXEL, 0, 0, 0, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_PIXEL, 126, 62, 0, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_PIXEL, 127, 63, 0, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_PIXEL, -256, -256, 255, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_PIXEL, 255, 255, 255, 2'd3));
		send_command(pack_command(pfde_pkg::CMD_HLINE, -5, 3, 255, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_HLINE, 10, 4, 0, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_VLINE, 7, -3, 20, pfde_pkg::COLOR_INVERT));
		send_command(pack_command(pfde_pkg::CMD_VLINE, 200, 5, 255, pfde_pkg::COLOR_SET));
		send_command(pack_command(pfde_pkg::CMD_READ, 7, 8, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_READ, 126, 62, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_READ, -1, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_READ, 128, 64, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_VLINE, 7, 0, 8, 2'd3));
		send_command(pack_command(pfde_pkg::CMD_READ, 7, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_NONE, 255, -1, 255, 2'd3));
		send_command(pack_command(pfde_pkg::CMD_FULL, 0, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_CLEAR, 0, 0, 0, pfde_pkg::COLOR_CLEAR));
		send_command(pack_command(pfde_pkg::CMD_READ, 7, 8, 0, pfde_pkg::COLOR_CLEAR));
	endtask

	// random commands, mostly draws inside the screen mixed with reads
	task automatic test_random(input int count);
		int kind, x, y;
		pfde_pkg::cmd_t cmd;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) cmd = pfde_pkg::CMD_PIXEL;
			else if (kind < 45) cmd = pfde_pkg::CMD_HLINE;
			else if (kind < 60) cmd = pfde_pkg::CMD_VLINE;
			else if (kind < 88) cmd = pfde_pkg::CMD_READ;
			else if (kind < 92) cmd = pfde_pkg::CMD_BEGIN;
			else if (kind < 94) cmd = pfde_pkg::CMD_FULL;
			else if (kind < 95) cmd = pfde_pkg::CMD_CLEAR;
			else cmd = pfde_pkg::CMD_NONE;
			if ($urandom_range(0, 7) == 0) begin
				x = $signed(9'($urandom));
				y = $signed(9'($urandom));
			end else begin
				x = $urandom_range(0, COLS + 3) - 2;
				y = $urandom_range(0, ROWS + 3) - 2;
			end
			send_command(pack_command(cmd, x, y,
				$urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 24),
				any_color()));
		end
	endtask

	// clip window settings including empty, full and out-of-screen ones
	task automatic test_windows();
		set_window(0, 0, 128, 64);
		test_random(300);
		set_window(10, 5, 40, 30);
		test_random(250);
		set_window(128, 64, 0, 0);
		test_random(60);
		set_window(255, 127, 255, 127);
		test_random(60);
		set_window(0, 0, 255, 127);
		test_random(200);
		set_window($urandom_range(0, 64), $urandom_range(0, 32),
			$urandom_range(32, 128), $urandom_range(16, 64));
		test_random(250);
		set_window(0, 0, 127, 63);
		test_random(150);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		draw_count = 0;
		read_count = 0;
		foreach (pixel_bytes[i])
			pixel_bytes[i] = 8'd0;
		rect_x0 = 0; rect_y0 = 0; rect_x1 = 0; rect_y1 = 0;
		win_x0 = 0; win_y0 = 0; win_x1 = 127; win_y1 = 63;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_windows();
		wait_drained();
		repeat (400) @(posedge clk);
		$display("checked %0d result beats: %0d visible draws, %0d reads, 7 clip windows",
			beats_checked, draw_count, read_count);
		if (error_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(100ms);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pfde_pkg.sv
rtl/pfde_ram.sv
rtl/page_framebuffer_draw_engine_top.sv
sim/page_framebuffer_draw_engine_top_test.sv
